[rtl/core/lst_pkg.sv]
// ----------------------------------------------------------------------------
// lst_pkg
// Types and constants shared by the latency statistics table and its parts.
// ----------------------------------------------------------------------------
package lst_pkg;

    localparam int INDEX_W    = 5;
    localparam int DURATION_W = 32;
    localparam int COUNT_W    = 32;
    localparam int TOTAL_W    = 64;

    // one quotient bit per step over the whole total
    localparam int DIV_STEPS  = TOTAL_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_REPORT = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic [INDEX_W-1:0]    metric_index;
        logic [DURATION_W-1:0] elapsed_us;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0]    report_index;
        logic [COUNT_W-1:0]    sample_count;
        logic [DURATION_W-1:0] average_us;
        logic [DURATION_W-1:0] maximum_us;
        logic [DURATION_W-1:0] minimum_us;
        logic [DURATION_W-1:0] latest_us;
        logic                  end_of_report;
    } out_item_t;

    // one table row as it sits in memory
    typedef struct packed {
        logic [COUNT_W-1:0]    sample_count;
        logic [TOTAL_W-1:0]    duration_total;
        logic [DURATION_W-1:0] duration_max;
        logic [DURATION_W-1:0] duration_min;
        logic [DURATION_W-1:0] duration_latest;
    } entry_t;

    typedef struct packed {
        logic                  done;
        logic [DURATION_W-1:0] quotient;
    } div_result_t;

endpackage

[rtl/core/latency_statistics_table.sv]
// ----------------------------------------------------------------------------
// latency_statistics_table
// Per-metric count, total, max, min and last duration kept in one RAM row
// per metric; a report transaction streams every row out and clears the table.
// ----------------------------------------------------------------------------
//  channel   direction  ports                      payload
//  s_        in         s_valid s_ready s_data     lst_pkg::in_item_t
//  m_        out        m_valid m_ready m_data     lst_pkg::out_item_t
//
//  record transactions: one per cycle; RAM read in the accept cycle, write
//    back in the next, a row written in one cycle is forwarded to the next read
//  report transactions: each metric's row is read, loaded, divided by the
//    bit-serial divider and output, plus the wait on m_ready for each result
//  s_ready is low for the whole sweep; the row valid bits all clear at once
//    at the end of a sweep and at reset, so no clearing pass is needed
// ----------------------------------------------------------------------------
module latency_statistics_table #(
    parameter int NUM_METRICS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lst_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lst_pkg::out_item_t  m_data
);

    localparam int ADDR_W  = (NUM_METRICS > 1) ? $clog2(NUM_METRICS) : 1;
    localparam int ENTRY_W = $bits(lst_pkg::entry_t);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_RECORD = 5'b00010,
        ST_READ   = 5'b00100,
        ST_LOAD   = 5'b01000,
        ST_DIVIDE = 5'b10000
    } state_t;

    // output stage runs alongside ST_DIVIDE's follow-up; see m_valid_reg
    state_t state_reg, state_next;

    logic                               s_fire;
    logic                               m_fire;
    logic                               s_idx_ok;

    logic [ADDR_W-1:0]                  rec_addr_reg;
    logic                               rec_ok_reg;
    logic [lst_pkg::DURATION_W-1:0]     rec_dur_reg;

    logic [ADDR_W-1:0]                  sweep_reg;
    logic                               sweep_last;
    logic                               out_wait_reg;

    logic [NUM_METRICS-1:0]             valid_reg;
    logic                               fwd_hit_reg;
    lst_pkg::entry_t                    fwd_data_reg;

    logic                               rd_en;
    logic [ADDR_W-1:0]                  rd_addr;
    logic [ENTRY_W-1:0]                 rd_data;
    logic                               wr_en;
    logic [ADDR_W-1:0]                  wr_addr;
    lst_pkg::entry_t                    wr_entry;

    logic [ADDR_W-1:0]                  cur_addr;
    lst_pkg::entry_t                    cur_entry;

    logic                               m_valid_reg;
    lst_pkg::out_item_t                 m_data_reg;
    lst_pkg::div_result_t               div_result;

    assign s_ready  = (state_reg == ST_IDLE) || (state_reg == ST_RECORD);
    assign s_fire   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign m_fire   = m_valid_reg && m_ready;
    assign s_idx_ok = ({1'b0, s_data.metric_index} < (lst_pkg::INDEX_W + 1)'(NUM_METRICS));
    assign sweep_last = (sweep_reg == ADDR_W'(NUM_METRICS - 1));

    // ------------------------------------------------------------------------
    // row storage
    // ------------------------------------------------------------------------
    assign rd_en   = (s_fire && (s_data.mode == lst_pkg::MODE_RECORD))
                     || (state_reg == ST_READ);
    assign rd_addr = (state_reg == ST_READ) ? sweep_reg
                                            : s_data.metric_index[ADDR_W-1:0];

    assign cur_addr = (state_reg == ST_LOAD) ? sweep_reg : rec_addr_reg;

    // rows never written since the last clear read as zero
    always_comb begin
        if (fwd_hit_reg) begin
            cur_entry = fwd_data_reg;
        end else if (valid_reg[cur_addr]) begin
            cur_entry = lst_pkg::entry_t'(rd_data);
        end else begin
            cur_entry = '0;
        end
    end

    always_comb begin
        wr_entry.sample_count    = cur_entry.sample_count + 1'b1;
        wr_entry.duration_total  = cur_entry.duration_total
                                   + {{(lst_pkg::TOTAL_W - lst_pkg::DURATION_W){1'b0}},
                                      rec_dur_reg};
        wr_entry.duration_latest = rec_dur_reg;
        wr_entry.duration_max    = (cur_entry.duration_max < rec_dur_reg)
                                   ? rec_dur_reg : cur_entry.duration_max;
        // a zero minimum is treated as empty, so any sample replaces it
        wr_entry.duration_min    = ((cur_entry.duration_min == '0)
                                    || (cur_entry.duration_min > rec_dur_reg))
                                   ? rec_dur_reg : cur_entry.duration_min;
    end

    assign wr_en   = (state_reg == ST_RECORD) && rec_ok_reg;
    assign wr_addr = rec_addr_reg;

    lst_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (NUM_METRICS),
        .ADDR_W (ADDR_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (ENTRY_W'(wr_entry)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lst_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_LOAD),
        .dividend (cur_entry.duration_total),
        .divisor  (cur_entry.sample_count),
        .result   (div_result)
    );

    // ------------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE, ST_RECORD: begin
                if (s_fire) begin
                    state_next = (s_data.mode == lst_pkg::MODE_REPORT) ? ST_READ
                                                                       : ST_RECORD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (m_fire) begin
                    state_next = sweep_last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            fwd_hit_reg  <= 1'b0;
            rec_ok_reg   <= 1'b0;
            sweep_reg    <= '0;
            m_valid_reg  <= 1'b0;
            out_wait_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fwd_hit_reg <= wr_en && rd_en && (rd_addr == wr_addr);

            if (s_fire) begin
                rec_ok_reg <= (s_data.mode == lst_pkg::MODE_RECORD) && s_idx_ok;
                sweep_reg  <= '0;
            end else if (state_reg == ST_RECORD) begin
                rec_ok_reg <= 1'b0;
            end

            if (state_reg == ST_LOAD) begin
                out_wait_reg <= 1'b1;
            end else if (div_result.done) begin
                out_wait_reg <= 1'b0;
                m_valid_reg  <= 1'b1;
            end else if (m_fire) begin
                m_valid_reg <= 1'b0;
                if (!sweep_last) begin
                    sweep_reg <= sweep_reg + 1'b1;
                end
            end

            if (m_fire && sweep_last) begin
                valid_reg <= '0;
            end else if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rec_addr_reg <= s_data.metric_index[ADDR_W-1:0];
            rec_dur_reg  <= s_data.elapsed_us;
        end
        fwd_data_reg <= wr_entry;

        if (state_reg == ST_LOAD) begin
            m_data_reg.report_index  <= lst_pkg::INDEX_W'(sweep_reg);
            m_data_reg.sample_count  <= cur_entry.sample_count;
            m_data_reg.maximum_us    <= cur_entry.duration_max;
            m_data_reg.minimum_us    <= cur_entry.duration_min;
            m_data_reg.latest_us     <= cur_entry.duration_latest;
            m_data_reg.end_of_report <= sweep_last;
        end
        if (div_result.done) begin
            m_data_reg.average_us <= (m_data_reg.sample_count == '0)
                                     ? '0 : div_result.quotient;
        end
    end

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    property p_fwd_follows_write;
        @(posedge aclk) disable iff (!aresetn)
        fwd_hit_reg |-> $past(wr_en);
    endproperty
    a_fwd_follows_write: assert property (p_fwd_follows_write)
        else $error("forwarding without a write in the previous cycle");

    property p_table_cleared_after_report;
        @(posedge aclk) disable iff (!aresetn)
        m_fire && m_data_reg.end_of_report |=> (valid_reg == '0);
    endproperty
    a_table_cleared_after_report: assert property (p_table_cleared_after_report)
        else $error("table not cleared after the last report transaction");

    property p_last_result_index;
        @(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.end_of_report
            |-> (m_data_reg.report_index == lst_pkg::INDEX_W'(NUM_METRICS - 1));
    endproperty
    a_last_result_index: assert property (p_last_result_index)
        else $error("end of report marked on a metric other than the last");

    property p_result_only_in_sweep;
        @(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (state_reg == ST_DIVIDE) && !out_wait_reg;
    endproperty
    a_result_only_in_sweep: assert property (p_result_only_in_sweep)
        else $error("result offered outside the report sweep");

    property p_no_write_during_sweep;
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) || (state_reg == ST_DIVIDE) |-> !wr_en && !s_ready;
    endproperty
    a_no_write_during_sweep: assert property (p_no_write_during_sweep)
        else $error("table written or input taken during a report sweep");

endmodule

[rtl/core/lst_ram.sv]
// ----------------------------------------------------------------------------
// lst_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lst_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/lst_divider.sv]
// ----------------------------------------------------------------------------
// lst_divider
// Bit-serial restoring divider, 64-bit total by 32-bit count, one bit a cycle.
// ----------------------------------------------------------------------------
module lst_divider (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [lst_pkg::TOTAL_W-1:0]      dividend,
    input  logic [lst_pkg::COUNT_W-1:0]      divisor,
    output lst_pkg::div_result_t             result
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [lst_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [lst_pkg::COUNT_W-1:0]     rem_reg;
    logic [lst_pkg::TOTAL_W-1:0]     quo_reg;
    logic [lst_pkg::COUNT_W-1:0]     div_reg;

    logic [lst_pkg::COUNT_W:0]       rem_shift;
    logic [lst_pkg::COUNT_W:0]       rem_diff;
    logic                            fits;

    // dividend bits shift out of the top while quotient bits enter the bottom
    assign rem_shift = {rem_reg, quo_reg[lst_pkg::TOTAL_W-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign fits      = (rem_shift >= {1'b0, div_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == lst_pkg::DIV_CNT_W'(lst_pkg::DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[lst_pkg::TOTAL_W-2:0], fits};
            rem_reg <= fits ? rem_diff[lst_pkg::COUNT_W-1:0]
                            : rem_shift[lst_pkg::COUNT_W-1:0];
        end
    end

    assign result.done     = done_reg;
    assign result.quotient = quo_reg[lst_pkg::DURATION_W-1:0];

    property p_no_restart_while_busy;
        @(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg;
    endproperty
    a_no_restart_while_busy: assert property (p_no_restart_while_busy)
        else $error("divider restarted while busy");

    property p_done_after_last_step;
        @(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg) && !busy_reg;
    endproperty
    a_done_after_last_step: assert property (p_done_after_last_step)
        else $error("divider done without finishing a division");

    property p_done_single_pulse;
        @(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg;
    endproperty
    a_done_single_pulse: assert property (p_done_single_pulse)
        else $error("divider done held longer than one cycle");

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for latency_statistics_table: a local copy of the
// statistics table predicts every report row, and a checker compares each
// row that leaves the block, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_METRICS  = 32;
    localparam int RANDOM_ITEMS = 100;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 200;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    lst_pkg::in_item_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    lst_pkg::out_item_t m_data;

    // local copy of the table
    logic [lst_pkg::COUNT_W-1:0]    stat_count  [NUM_METRICS];
    logic [lst_pkg::TOTAL_W-1:0]    stat_total  [NUM_METRICS];
    logic [lst_pkg::DURATION_W-1:0] stat_max    [NUM_METRICS];
    logic [lst_pkg::DURATION_W-1:0] stat_min    [NUM_METRICS];
    logic [lst_pkg::DURATION_W-1:0] stat_latest [NUM_METRICS];

    lst_pkg::out_item_t expected_rows[$];
    lst_pkg::out_item_t oldest_row;

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  stall_left     = 0;
    bit  source_idling  = 1'b1;
    bit  sink_idling    = 1'b1;
    logic sink_hold     = 1'b0;

    latency_statistics_table #(
        .NUM_METRICS(NUM_METRICS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    function automatic void clear_statistics();
        for (int k = 0; k < NUM_METRICS; k++) begin
            stat_count[k]  = '0;
            stat_total[k]  = '0;
            stat_max[k]    = '0;
            stat_min[k]    = '0;
            stat_latest[k] = '0;
        end
    endfunction

    // update the table for one transaction; a report queues one row per metric
    function automatic void predict_statistics(input lst_pkg::in_item_t item);
        lst_pkg::out_item_t          row;
        logic [lst_pkg::TOTAL_W-1:0] quotient;
        if (item.mode == lst_pkg::MODE_RECORD) begin
            if (item.metric_index < NUM_METRICS) begin
                stat_count[item.metric_index]  = stat_count[item.metric_index] + 1'b1;
                stat_total[item.metric_index]  = stat_total[item.metric_index]
                                                 + lst_pkg::TOTAL_W'(item.elapsed_us);
                stat_latest[item.metric_index] = item.elapsed_us;
                if (stat_max[item.metric_index] < item.elapsed_us)
                    stat_max[item.metric_index] = item.elapsed_us;
                // zero minimum means empty, so any sample replaces it
                if (stat_min[item.metric_index] == '0 ||
                    stat_min[item.metric_index] > item.elapsed_us)
                    stat_min[item.metric_index] = item.elapsed_us;
            end
        end else begin
            for (int k = 0; k < NUM_METRICS; k++) begin
                quotient = '0;
                if (stat_count[k] != '0)
                    quotient = stat_total[k] / lst_pkg::TOTAL_W'(stat_count[k]);
                row.report_index  = lst_pkg::INDEX_W'(k);
                row.sample_count  = stat_count[k];
                row.average_us    = quotient[lst_pkg::DURATION_W-1:0];
                row.maximum_us    = stat_max[k];
                row.minimum_us    = stat_min[k];
                row.latest_us     = stat_latest[k];
                row.end_of_report = (k == NUM_METRICS - 1);
                expected_rows.push_back(row);
            end
            clear_statistics();
        end
    endfunction

    task automatic note_mismatch(input string what, input int metric,
                                 input logic [63:0] want, input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch metric %0d %s: expected %0h, got %0h",
                     metric, what, want, got);
    endtask

    // accepted input transactions feed the predictor
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            predict_statistics(s_data);
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_rows.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result for metric %0d", m_data.report_index);
            end else begin
                oldest_row = expected_rows.pop_front();
                if (m_data.report_index !== oldest_row.report_index)
                    note_mismatch("report_index", oldest_row.report_index,
                                  oldest_row.report_index, m_data.report_index);
                if (m_data.sample_count !== oldest_row.sample_count)
                    note_mismatch("sample_count", oldest_row.report_index,
                                  oldest_row.sample_count, m_data.sample_count);
                if (m_data.average_us !== oldest_row.average_us)
                    note_mismatch("average_us", oldest_row.report_index,
                                  oldest_row.average_us, m_data.average_us);
                if (m_data.maximum_us !== oldest_row.maximum_us)
                    note_mismatch("maximum_us", oldest_row.report_index,
                                  oldest_row.maximum_us, m_data.maximum_us);
                if (m_data.minimum_us !== oldest_row.minimum_us)
                    note_mismatch("minimum_us", oldest_row.report_index,
                                  oldest_row.minimum_us, m_data.minimum_us);
                if (m_data.latest_us !== oldest_row.latest_us)
                    note_mismatch("latest_us", oldest_row.report_index,
                                  oldest_row.latest_us, m_data.latest_us);
                if (m_data.end_of_report !== oldest_row.end_of_report)
                    note_mismatch("end_of_report", oldest_row.report_index,
                                  oldest_row.end_of_report, m_data.end_of_report);
            end
        end
    end

    // result side: random stall bursts, plus the long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (sink_hold) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (sink_idling && $urandom_range(0, 9) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 12);
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("** latency_statistics_table: FAILED **");
        $finish;
    end

    // offer one transaction and return once it has been accepted
    task automatic send_item(input logic mode, input logic [lst_pkg::INDEX_W-1:0] metric,
                             input logic [lst_pkg::DURATION_W-1:0] duration);
        lst_pkg::in_item_t item;
        item.mode         = mode;
        item.metric_index = metric;
        item.elapsed_us   = duration;
        if (source_idling && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drop valid so the last transaction is not taken twice, then drain
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_rows.size() != 0) @(posedge aclk);
    endtask

    task automatic hold_sink(input int cycles);
        sink_hold <= 1'b1;
        repeat (cycles) @(posedge aclk);
        sink_hold <= 1'b0;
    endtask

    function automatic logic [lst_pkg::DURATION_W-1:0] pick_duration();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return lst_pkg::DURATION_W'($urandom_range(1, 100));
            3:       return lst_pkg::DURATION_W'($urandom_range(0, 65535));
            default: return lst_pkg::DURATION_W'($urandom);
        endcase
    endfunction

    function automatic logic [lst_pkg::INDEX_W-1:0] pick_index();
        // a few hot metrics collect many samples each
        if ($urandom_range(0, 1) == 0)
            return lst_pkg::INDEX_W'($urandom_range(0, 3));
        return lst_pkg::INDEX_W'($urandom_range(0, NUM_METRICS - 1));
    endfunction

    // every metric reports zero straight out of reset
    task automatic test_empty_report();
        send_item(lst_pkg::MODE_REPORT, '1, '1);
        wait_for_results();
    endtask

    task automatic test_field_extremes();
        send_item(lst_pkg::MODE_RECORD, 5'd0, '0);             // zero keeps minimum empty
        send_item(lst_pkg::MODE_RECORD, 5'd0, 32'd7);          // fills the empty minimum
        send_item(lst_pkg::MODE_RECORD, 5'd0, 32'd3);
        send_item(lst_pkg::MODE_RECORD, 5'd0, '0);             // zero empties the minimum
        send_item(lst_pkg::MODE_RECORD, 5'd0, 32'd9);
        send_item(lst_pkg::MODE_RECORD, 5'd31, '1);
        send_item(lst_pkg::MODE_RECORD, 5'd31, '1);            // total past 32 bits
        send_item(lst_pkg::MODE_RECORD, 5'd31, 32'd1);
        send_item(lst_pkg::MODE_RECORD, 5'd1, 32'd1);
        send_item(lst_pkg::MODE_RECORD, 5'd1, 32'd1);
        send_item(lst_pkg::MODE_RECORD, 5'd16, 32'h8000_0000);
        send_item(lst_pkg::MODE_RECORD, 5'd15, 32'h7fff_ffff);
        send_item(lst_pkg::MODE_RECORD, 5'd21, 32'h5555_5555);
        send_item(lst_pkg::MODE_RECORD, 5'd10, 32'haaaa_aaaa);
        // report ignores its index and duration fields
        send_item(lst_pkg::MODE_REPORT, 5'd21, 32'h1234_5678);
        wait_for_results();
        send_item(lst_pkg::MODE_REPORT, '0, '0);               // table was cleared by the sweep
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            source_idling = !(n >= 60 && n < 90);
            sink_idling   = source_idling;
            if ($urandom_range(0, 19) == 0)
                send_item(lst_pkg::MODE_REPORT, lst_pkg::INDEX_W'($urandom),
                          lst_pkg::DURATION_W'($urandom));
            else
                send_item(lst_pkg::MODE_RECORD, pick_index(), pick_duration());
        end
        send_item(lst_pkg::MODE_REPORT, lst_pkg::INDEX_W'($urandom),
                  lst_pkg::DURATION_W'($urandom));
        wait_for_results();
    endtask

    // results back up while records keep arriving behind the sweep
    task automatic test_backpressure();
        send_item(lst_pkg::MODE_RECORD, 5'd2, lst_pkg::DURATION_W'($urandom));
        fork
            hold_sink(HOLD_CYCLES);
        join_none
        send_item(lst_pkg::MODE_REPORT, '0, '0);
        for (int n = 0; n < 10; n++)
            send_item(lst_pkg::MODE_RECORD, pick_index(), pick_duration());
        send_item(lst_pkg::MODE_REPORT, '0, '0);
        wait_for_results();
    endtask

    // no idling: back to back records, first on one metric and then over three, exercise the forwarding path
    task automatic test_back_to_back();
        source_idling = 1'b0;
        sink_idling   = 1'b0;
        for (int n = 0; n < 24; n++)
            send_item(lst_pkg::MODE_RECORD,
                      (n < 12) ? 5'd5 : lst_pkg::INDEX_W'(n % 3), pick_duration());
        send_item(lst_pkg::MODE_REPORT, '0, '0);
        send_item(lst_pkg::MODE_REPORT, '1, '1);
        wait_for_results();
    endtask

    initial begin
        clear_statistics();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_report();
        test_field_extremes();
        test_random_traffic();
        test_backpressure();
        test_back_to_back();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && expected_rows.size() == 0) begin
            $display("** latency_statistics_table: PASSED **");
        end else begin
            $display("** latency_statistics_table: FAILED **");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/lst_pkg.sv
rtl/core/lst_ram.sv
rtl/core/lst_divider.sv
rtl/core/latency_statistics_table.sv
test/testbench.sv
